FILE: design/kwc_pkg.sv
// Shared types, constants and wheel helper functions for the keyed wheel cipher.
`timescale 1ns / 1ps

package kwc_pkg;

    localparam int KEY_BYTES  = 61;
    localparam int KEY_AW     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int WHEEL_SIZE = 26 + 26 + 10 + 15;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] WHEEL_SIZE8 = 8'(WHEEL_SIZE);

    localparam logic [0:0] MODE_LOAD = 1'b0;
    localparam logic [0:0] MODE_CHAR = 1'b1;

    localparam logic [0:0] CFG_DIRECTION = 1'b0;
    localparam logic [0:0] CFG_CHAINING  = 1'b1;

    typedef struct packed {
        logic       direction;
        logic       chaining_on;
    } t_cfg;

    // One classified character on its way from the front to the back.
    typedef struct packed {
        logic       first;
        logic       is_wheel;
        logic       eos;
        logic [7:0] char_in;
        logic [6:0] cpos;
        logic [6:0] cmod;
        logic [6:0] kmod;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qwrite;

    function automatic logic is_wheel(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h21 && c <= 8'h2f);
    endfunction

    function automatic logic [6:0] wheel_pos(input logic [7:0] c);
        logic [7:0] p;
        p = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)      p = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h5a) p = c - 8'h41 + 8'd10;
        else if (c >= 8'h61 && c <= 8'h7a) p = c - 8'h61 + 8'd36;
        else if (c >= 8'h21 && c <= 8'h2f) p = c - 8'h21 + 8'd62;
        return p[6:0];
    endfunction

    function automatic logic [7:0] wheel_char(input logic [6:0] q);
        logic [7:0] qq;
        qq = {1'b0, q};
        if (qq < 8'd10)      return 8'h30 + qq;
        else if (qq < 8'd36) return 8'h41 + (qq - 8'd10);
        else if (qq < 8'd62) return 8'h61 + (qq - 8'd36);
        else                 return 8'h21 + (qq - 8'd62);
    endfunction

    // Byte reduced modulo the wheel length; a priority chain of compares, no divider.
    function automatic logic [6:0] mod_wheel(input logic [7:0] v);
        logic [7:0] r;
        if (v >= 8'(3 * WHEEL_SIZE))      r = v - 8'(3 * WHEEL_SIZE);
        else if (v >= 8'(2 * WHEEL_SIZE)) r = v - 8'(2 * WHEEL_SIZE);
        else if (v >= WHEEL_SIZE8)        r = v - WHEEL_SIZE8;
        else                              r = v;
        return r[6:0];
    endfunction

endpackage

FILE: design/kwc_front.sv
// Front end: accepts items, keeps the keystream table and key position, classifies characters.
`timescale 1ns / 1ps

module kwc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic                     i_first,
    input  logic [5:0]               i_key_index,
    input  logic [7:0]               i_key_byte,
    input  logic [7:0]               i_char_in,
    input  logic [kwc_pkg::Q_CW-1:0] i_q_count,
    output kwc_pkg::t_qwrite         o_qwrite
);

    logic [7:0]               r_keystream [kwc_pkg::KEY_BYTES];
    logic [kwc_pkg::KEY_AW-1:0] r_keypos;
    logic [kwc_pkg::KEY_AW-1:0] n_keypos;
    logic [kwc_pkg::KEY_AW-1:0] w_rd_addr;
    logic                     r_s1_valid;
    logic                     r_s1_first;
    logic [7:0]               r_s1_char;
    logic [7:0]               r_kdata;
    logic                     w_accept;
    logic [kwc_pkg::Q_CW:0]   w_pending;

    // Leave room for the item held in the read stage.
    assign w_pending = {1'b0, i_q_count} + {{kwc_pkg::Q_CW{1'b0}}, r_s1_valid};
    assign o_ready   = (w_pending < (kwc_pkg::Q_CW + 1)'(kwc_pkg::Q_DEPTH));
    assign w_accept  = i_valid && o_ready;

    assign w_rd_addr = i_first ? '0 : r_keypos;
    assign n_keypos  = (w_rd_addr == kwc_pkg::KEY_AW'(kwc_pkg::KEY_BYTES - 1)) ?
                       '0 : w_rd_addr + kwc_pkg::KEY_AW'(1);

    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == kwc_pkg::MODE_LOAD &&
            {1'b0, i_key_index} < 7'(kwc_pkg::KEY_BYTES)) begin
            r_keystream[i_key_index[kwc_pkg::KEY_AW-1:0]] <= i_key_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == kwc_pkg::MODE_CHAR) begin
            r_kdata    <= r_keystream[w_rd_addr];
            r_s1_first <= i_first;
            r_s1_char  <= i_char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keypos   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && i_mode == kwc_pkg::MODE_CHAR;
            if (w_accept && i_mode == kwc_pkg::MODE_CHAR) begin
                r_keypos <= n_keypos;
            end
        end
    end

    always_comb begin
        o_qwrite.valid         = r_s1_valid;
        o_qwrite.item.first    = r_s1_first;
        o_qwrite.item.is_wheel = kwc_pkg::is_wheel(r_s1_char);
        o_qwrite.item.eos      = (r_s1_char == 8'h00);
        o_qwrite.item.char_in  = r_s1_char;
        o_qwrite.item.cpos     = kwc_pkg::wheel_pos(r_s1_char);
        o_qwrite.item.cmod     = kwc_pkg::mod_wheel(r_s1_char);
        o_qwrite.item.kmod     = kwc_pkg::mod_wheel(r_kdata);
    end

endmodule

FILE: design/kwc_queue.sv
// Short queue that decouples the front end from the substitution back end.
`timescale 1ns / 1ps

module kwc_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kwc_pkg::t_qwrite         i_qwrite,
    input  logic                     i_pop,
    output kwc_pkg::t_item           o_head,
    output logic [kwc_pkg::Q_CW-1:0] o_count
);

    kwc_pkg::t_item           r_mem [kwc_pkg::Q_DEPTH];
    logic [kwc_pkg::Q_AW-1:0] r_wr_ptr;
    logic [kwc_pkg::Q_AW-1:0] r_rd_ptr;
    logic [kwc_pkg::Q_CW-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_qwrite.valid) begin
            r_mem[r_wr_ptr] <= i_qwrite.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_qwrite.valid) r_wr_ptr <= r_wr_ptr + kwc_pkg::Q_AW'(1);
            if (i_pop)          r_rd_ptr <= r_rd_ptr + kwc_pkg::Q_AW'(1);
            case ({i_qwrite.valid, i_pop})
                2'b10:   r_count <= r_count + kwc_pkg::Q_CW'(1);
                2'b01:   r_count <= r_count - kwc_pkg::Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/kwc_back.sv
// Back end: chain value, wheel substitution and the output register.
`timescale 1ns / 1ps

module kwc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kwc_pkg::t_cfg            i_cfg,
    input  kwc_pkg::t_item           i_head,
    input  logic [kwc_pkg::Q_CW-1:0] i_q_count,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_char_out,
    output logic                     o_substituted,
    output logic                     o_end_of_string
);

    logic [6:0] r_chain_mod;
    logic [6:0] w_chain_use;
    logic [7:0] w_off_sum;
    logic [6:0] w_off;
    logic [7:0] w_enc_sum;
    logic [6:0] w_pos;
    logic [7:0] w_res;
    logic       r_out_valid;
    logic [7:0] r_char_out;
    logic       r_substituted;
    logic       r_eos;

    assign o_pop = (i_q_count != '0) && (!r_out_valid || i_ready);

    // Chain held as its residue modulo the wheel length.
    assign w_chain_use = i_head.first ? 7'd0 : r_chain_mod;
    assign w_off_sum   = {1'b0, i_head.kmod} + {1'b0, w_chain_use};
    assign w_off       = (w_off_sum >= kwc_pkg::WHEEL_SIZE8) ?
                         7'(w_off_sum - kwc_pkg::WHEEL_SIZE8) : w_off_sum[6:0];
    assign w_enc_sum   = {1'b0, i_head.cpos} + {1'b0, w_off};

    always_comb begin
        if (i_cfg.direction) begin
            if (i_head.cpos >= w_off) w_pos = i_head.cpos - w_off;
            else w_pos = 7'({1'b0, i_head.cpos} + kwc_pkg::WHEEL_SIZE8 - {1'b0, w_off});
        end else begin
            if (w_enc_sum >= kwc_pkg::WHEEL_SIZE8) w_pos = 7'(w_enc_sum - kwc_pkg::WHEEL_SIZE8);
            else w_pos = w_enc_sum[6:0];
        end
    end

    assign w_res = kwc_pkg::wheel_char(w_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_mod <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (i_cfg.chaining_on && i_head.is_wheel) begin
                    r_chain_mod <= i_cfg.direction ? i_head.cmod : kwc_pkg::mod_wheel(w_res);
                end else if (i_head.first) begin
                    r_chain_mod <= 7'd0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char_out    <= i_head.is_wheel ? w_res : i_head.char_in;
            r_substituted <= i_head.is_wheel;
            r_eos         <= i_head.eos;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_char_out      = r_char_out;
    assign o_substituted   = r_substituted;
    assign o_end_of_string = r_eos;

endmodule

FILE: design/keyed_wheel_cipher_with_chaining_top.sv
// Top level of the keyed wheel substitution cipher with ciphertext chaining.
//
//  Channel   Direction  Payload                                   Handshake
//  s_axis    in         tuser{first,mode} tdata{char,byte,index}  tvalid/tready
//  m_axis    out        tdata char_out, tuser subst, tlast eos    tvalid/tready
//  cfg       in         index 0 direction, 1 chaining_on          i_cfg_we only
//
//  One item per clock is taken while the output side does not stall, load and character
//  items alike; the chain update in the back end, done at each pop, sets that rate.
//  At the earliest, o_m_axis_tvalid rises once its accepted character has passed the keystream
//  read at the accepting edge, the queue write and the output register;
//  load items give no result.
//  Reset (synchronous, active low) clears key position, chain, queue and config;
//  the keystream table is not cleared and must be loaded before use.
//  o_s_axis_tready drops once the queue and the read stage hold four characters,
//  which happens only while the output side stalls.
`timescale 1ns / 1ps

module keyed_wheel_cipher_with_chaining_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // key_index[5:0], key_byte[13:6], char_in[21:14], zero
    input  logic [1:0]  i_s_axis_tuser,  // mode[0], first[1]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // char_out[7:0]
    output logic        o_m_axis_tuser,  // substituted[0]
    output logic        o_m_axis_tlast,  // end_of_string
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);

    kwc_pkg::t_cfg           r_cfg;
    kwc_pkg::t_qwrite        w_qwrite;
    kwc_pkg::t_item          w_head;
    logic [kwc_pkg::Q_CW-1:0] w_q_count;
    logic                    w_pop;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction   <= 1'b0;
            r_cfg.chaining_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kwc_pkg::CFG_DIRECTION: r_cfg.direction   <= i_cfg_data[0];
                kwc_pkg::CFG_CHAINING:  r_cfg.chaining_on <= i_cfg_data[0];
                default:                r_cfg             <= r_cfg;
            endcase
        end
    end

    // Front: accept, load keystream, read key byte, classify the character.
    kwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser[0]),
        .i_first     (i_s_axis_tuser[1]),
        .i_key_index (i_s_axis_tdata[5:0]),
        .i_key_byte  (i_s_axis_tdata[13:6]),
        .i_char_in   (i_s_axis_tdata[21:14]),
        .i_q_count   (w_q_count),
        .o_qwrite    (w_qwrite)
    );

    kwc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qwrite (w_qwrite),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_count  (w_q_count)
    );

    // Back: apply offset, advance chain, hold result until the transaction completes.
    kwc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (w_head),
        .i_q_count       (w_q_count),
        .o_pop           (w_pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_char_out      (o_m_axis_tdata),
        .o_substituted   (o_m_axis_tuser),
        .o_end_of_string (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // The queue never takes a character while full, unless a pop frees a slot at the same time.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qwrite.valid |-> (w_q_count != kwc_pkg::Q_CW'(kwc_pkg::Q_DEPTH) || w_pop))
        else $error("queue overflow");

    // The back end pops only a queue that holds something.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_count != '0))
        else $error("queue underflow");

    // A terminator result carries a zero byte and no substitution flag.
    a_eos_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata == 8'h00 && !o_m_axis_tuser))
        else $error("terminator result malformed");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule
